// ----- rtl/signed_unsigned_divider_remainder_assert.svh -----
// Assertion macros for the signed/unsigned divider checker.
// Used by sudr_chk; relies on clk and rst_n being in scope.
`ifndef SIGNED_UNSIGNED_DIVIDER_REMAINDER_ASSERT_SVH
`define SIGNED_UNSIGNED_DIVIDER_REMAINDER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SUDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SUDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sudr_pkg.sv -----
// Shared types and constants for the signed/unsigned divider.
// No dependencies; imported by every module of the block.
package sudr_pkg;

  localparam int DATA_W    = 64;
  localparam int ACT_W     = 2;
  localparam int IN_DATA_W = 2 * DATA_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_SDIV = 2'd0,
    ACT_UDIV = 2'd1,
    ACT_SREM = 2'd2,
    ACT_UREM = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_A,
    ST_NEG_B,
    ST_DIV,
    ST_FIX
  } state_t;

endpackage

// ----- rtl/signed_unsigned_divider_remainder.sv -----
// Signed/unsigned integer divider with RISC-V M results (quotient or remainder
// of the low WIDTH bits of both operands). An accepted request passes through
// these steps before the block takes the next one: the accept, two steps that
// take operand magnitudes, WIDTH restoring shift-subtract steps (one quotient
// bit each) and one sign fixup step, which waits while the output register is
// full; all but the accept use one shared subtractor. A zero divisor skips
// straight to the fixup step. The result sits in an output register, so the
// next request is taken while it waits. Depends on sudr_pkg and sudr_alu.
module signed_unsigned_divider_remainder
  import sudr_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [63:0] dividend, [127:64] divisor
  input  logic [ACT_W-1:0]     in_tuser,   // [1:0] action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata   // [63:0] result
);

  localparam int CNT_W = $clog2(WIDTH);

  state_t             state_r, state_nxt;
  act_t               act_r, act_nxt;
  logic [WIDTH-1:0]   a_r, a_nxt;
  logic [WIDTH-1:0]   b_r, b_nxt;
  logic [WIDTH-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_a_r, neg_a_nxt;
  logic               neg_b_r, neg_b_nxt;
  logic               bzero_r, bzero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;

  logic [WIDTH:0]     alu_min;
  logic [WIDTH:0]     alu_sub;
  logic [WIDTH:0]     alu_diff;
  logic               alu_borrow;

  logic               in_fire;
  logic               out_free;
  logic               in_signed;
  logic               in_bzero;
  logic               want_rem;
  logic               fix_neg;
  logic [WIDTH-1:0]   fix_sel;
  logic [WIDTH-1:0]   fix_val;

  sudr_alu #(.W(WIDTH)) u_alu (
    .min_i    (alu_min),
    .sub_i    (alu_sub),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_signed = (act_t'(in_tuser) == ACT_SDIV) || (act_t'(in_tuser) == ACT_SREM);
  assign in_bzero  = ~|in_tdata[DATA_W +: WIDTH];
  assign want_rem  = (act_r == ACT_SREM) || (act_r == ACT_UREM);

  // Pick the fixup operand and its sign
  assign fix_sel = want_rem ? rem_r : a_r;
  assign fix_neg = want_rem ? neg_a_r : (neg_a_r ^ neg_b_r);

  // Route the shared subtractor by state
  always_comb begin
    alu_min = '0;
    alu_sub = '0;
    unique case (state_r)
      ST_NEG_A: alu_sub = {1'b0, a_r};
      ST_NEG_B: alu_sub = {1'b0, b_r};
      ST_DIV: begin
        alu_min = {rem_r, a_r[WIDTH-1]};
        alu_sub = {1'b0, b_r};
      end
      ST_FIX:   alu_sub = {1'b0, fix_sel};
      default: begin
        alu_min = '0;
        alu_sub = '0;
      end
    endcase
  end

  // Final value: divide-by-zero bypass or sign-corrected result
  always_comb begin
    if (bzero_r) begin
      fix_val = want_rem ? a_r : '1;
    end else if (fix_neg) begin
      fix_val = alu_diff[WIDTH-1:0];
    end else begin
      fix_val = fix_sel;
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_a_nxt     = neg_a_r;
    neg_b_nxt     = neg_b_r;
    bzero_nxt     = bzero_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt   = act_t'(in_tuser);
          a_nxt     = in_tdata[WIDTH-1:0];
          b_nxt     = in_tdata[DATA_W +: WIDTH];
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(WIDTH - 1);
          bzero_nxt = in_bzero;
          neg_a_nxt = in_signed && !in_bzero && in_tdata[WIDTH-1];
          neg_b_nxt = in_signed && !in_bzero && in_tdata[DATA_W+WIDTH-1];
          state_nxt = in_bzero ? ST_FIX : ST_NEG_A;
        end
      end
      ST_NEG_A: begin
        if (neg_a_r) begin
          a_nxt = alu_diff[WIDTH-1:0];
        end
        state_nxt = ST_NEG_B;
      end
      ST_NEG_B: begin
        if (neg_b_r) begin
          b_nxt = alu_diff[WIDTH-1:0];
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Restore on borrow, else keep the difference; shift in the quotient bit
        rem_nxt = alu_borrow ? alu_min[WIDTH-1:0] : alu_diff[WIDTH-1:0];
        a_nxt   = {a_r[WIDTH-2:0], !alu_borrow};
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIX: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = DATA_W'(fix_val);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_a_r    <= neg_a_nxt;
    neg_b_r    <= neg_b_nxt;
    bzero_r    <= bzero_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/sudr_alu.sv -----
// Shared subtractor of the divider: one (W+1)-bit subtract with borrow out.
// Serves operand negation, restoring steps and result sign fixup.
module sudr_alu
  import sudr_pkg::*;
#(
  parameter int W = 64
) (
  input  logic [W:0] min_i,
  input  logic [W:0] sub_i,
  output logic [W:0] diff_o,
  output logic       borrow_o
);

  logic [W+1:0] full;

  // Subtract with one guard bit to expose the borrow
  assign full     = {1'b0, min_i} - {1'b0, sub_i};
  assign diff_o   = full[W:0];
  assign borrow_o = full[W+1];

endmodule

// ----- rtl/sudr_chk.sv -----
// Port-level checker for the signed/unsigned divider, bound to the top level.
// Depends on sudr_pkg and signed_unsigned_divider_remainder_assert.svh.
`include "signed_unsigned_divider_remainder_assert.svh"

module sudr_chk
  import sudr_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [DATA_W-1:0]    out_tdata
);

  logic in_fire;
  logic stall;

  assign in_fire   = in_tvalid && in_tready;
  assign stall     = out_tvalid && !out_tready;

  // A stalled result holds
  `SUDR_ASSERT_NEXT(a_out_hold, stall, out_tvalid && $stable(out_tdata), "stalled result changed")

  // One request at a time: busy right after an accept
  `SUDR_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "request taken while busy")

  // Result bits above WIDTH stay zero
  `SUDR_ASSERT_NOW(a_upper_zero, out_tvalid, (out_tdata >> WIDTH) == '0, "upper result bits set")

  // A new result only comes out of a busy period
  `SUDR_ASSERT_NOW(a_result_from_work, $rose(out_tvalid), $past(!in_tready), "result from idle")

endmodule

bind signed_unsigned_divider_remainder sudr_chk #(.WIDTH(WIDTH)) u_sudr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
